// File: rtl/sis_pkg.sv
package sis_pkg;

    localparam int WORD_W    = 32;
    localparam int DEPTH_DEF = 64;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t value;
        logic  last;
    } in_word_t;

    typedef struct packed {
        word_t value_res;
        logic  last_res;
        logic  overflow;
    } out_word_t;

    // Chain operation broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctl_t;

endpackage

// File: rtl/signed_int_array_sorter_core.sv
// Ascending sorter for lists of signed 32-bit words, built as an insertion
// chain of DEPTH cells. While a list is loading one word is taken every
// cycle: each word is compared in parallel by every cell and lands in its
// place in the same cycle. Once the word marked last is taken, input is held
// off and the list drains from the head of the chain, one result per cycle
// when the consumer is ready. A list keeps at most DEPTH words; words beyond
// DEPTH are dropped and every result of that list carries the overflow flag.
// The chain is empty again after the final result, ready for the next list.
module signed_int_array_sorter_core
    import sis_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    word_t      cell_val   [DEPTH];
    logic [DEPTH-1:0] cell_valid;
    logic [DEPTH-1:0] cell_take;
    cell_ctl_t  ctl;

    logic drain_reg;
    logic drain_next;
    logic ovf_reg;
    logic ovf_next;
    logic in_acc;
    logic out_acc;
    logic full;

    assign full     = cell_valid[DEPTH-1];
    assign in_ready = !drain_reg;
    assign in_acc   = in_valid && in_ready;
    assign out_valid = drain_reg;
    assign out_acc  = out_valid && out_ready;

    assign ctl.insert = in_acc && !full;
    assign ctl.shift  = out_acc;

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            word_t l_val;
            logic  l_valid;
            logic  l_take;
            word_t r_val;
            logic  r_valid;

            if (i == 0)
            begin : g_head
                assign l_val   = '0;
                assign l_valid = 1'b0;
                assign l_take  = 1'b0;
            end
            else
            begin : g_mid_l
                assign l_val   = cell_val[i-1];
                assign l_valid = cell_valid[i-1];
                assign l_take  = cell_take[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign r_val   = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_val   = cell_val[i+1];
                assign r_valid = cell_valid[i+1];
            end

            sis_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .word       (in_data.value),
                .left_val   (l_val),
                .left_valid (l_valid),
                .left_take  (l_take),
                .right_val  (r_val),
                .right_valid(r_valid),
                .val        (cell_val[i]),
                .valid      (cell_valid[i]),
                .take       (cell_take[i])
            );
        end
    endgenerate

    assign out_data.value_res = cell_val[0];
    assign out_data.last_res  = !cell_valid[1];
    assign out_data.overflow  = ovf_reg;

    always_comb
    begin
        drain_next = drain_reg;
        ovf_next   = ovf_reg;
        if (in_acc)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            if (in_data.last)
            begin
                drain_next = 1'b1;
            end
        end
        if (out_acc && !cell_valid[1])
        begin
            drain_next = 1'b0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            drain_reg <= drain_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Occupied cells always form an unbroken run from the head.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & (cell_valid + 1'b1)) == '0)
        else $error("chain holds a gap");

    // A list that is draining is never empty.
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> cell_valid[0])
        else $error("draining an empty chain");

    // A stored word adds exactly one occupied cell.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.insert |=> $countones(cell_valid) == $past($countones(cell_valid)) + 1)
        else $error("insert did not grow the chain by one");

    // After the final result the chain is empty and overflow is cleared.
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_data.last_res) |=> (cell_valid == '0) && !ovf_reg && !drain_reg)
        else $error("chain not cleared after final word");

endmodule

// File: rtl/sis_cell.sv
module sis_cell
    import sis_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  word_t     word,
    input  word_t     left_val,
    input  logic      left_valid,
    input  logic      left_take,
    input  word_t     right_val,
    input  logic      right_valid,
    output word_t     val,
    output logic      valid,
    output logic      take
);

    word_t val_reg;
    word_t val_next;
    logic  valid_reg;
    logic  valid_next;

    // A cell gives way when it is empty or holds a strictly greater value, so
    // equal values keep their arrival order.
    assign take = !valid_reg || (val_reg > word);

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctl.shift)
        begin
            val_next   = right_val;
            valid_next = right_valid;
        end
        else if (ctl.insert && take)
        begin
            if (left_take)
            begin
                val_next   = left_val;
                valid_next = left_valid;
            end
            else
            begin
                val_next   = word;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign val   = val_reg;
    assign valid = valid_reg;

endmodule

// File: bench/signed_int_array_sorter_core_tb.sv
module signed_int_array_sorter_core_tb;
    import sis_pkg::*;

    localparam int CAP        = DEPTH_DEF;
    localparam int CYCLE_CAP  = 60000;
    localparam int CALM_TAIL  = 25;
    localparam int SETTLE     = 20;

    // How the values of one list are drawn.
    typedef enum int {
        VAL_WIDE,
        VAL_NARROW,
        VAL_EDGE,
        VAL_MIXED
    } val_style_e;

    typedef struct {
        in_word_t w;
        bit       hold_off;
    } feed_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    feed_t     feed_q[$];
    out_word_t sorted_due[$];
    word_t     chain_model[$];
    bit        spill_seen;

    int        src_gap;
    int        snk_gap;
    int        cycle_count;
    int        errors;
    int        words_taken;
    int        lists_sorted;
    int        lists_spilled;
    int        results_seen;
    int        words_queued;
    feed_t     next_feed;
    out_word_t due;

    signed_int_array_sorter_core #(
        .DEPTH(CAP)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Places one accepted word into the sorted copy of the chain and, on the
    // word marked last, releases the whole list as expected results.
    task automatic sort_in_word(input in_word_t w);
        int pos;
        int k;
        begin
            if (chain_model.size() < CAP) begin
                pos = chain_model.size();
                while (pos > 0 && chain_model[pos-1] > w.value)
                    pos--;
                chain_model.insert(pos, w.value);
            end else begin
                spill_seen = 1'b1;
            end
            if (w.last) begin
                for (k = 0; k < chain_model.size(); k++)
                    sorted_due.push_back('{value_res: chain_model[k],
                                           last_res:  (k == chain_model.size() - 1),
                                           overflow:  spill_seen});
                lists_sorted++;
                if (spill_seen)
                    lists_spilled++;
                chain_model.delete();
                spill_seen = 1'b0;
            end
        end
    endtask

    function automatic word_t pick_value(input val_style_e style);
        val_style_e s;
        begin
            s = (style == VAL_MIXED) ? val_style_e'($urandom_range(0, 2)) : style;
            case (s)
                VAL_NARROW: pick_value = word_t'($signed($urandom_range(0, 6)) - 3);
                VAL_EDGE:
                    case ($urandom_range(0, 4))
                        0:       pick_value = 32'sh8000_0000;
                        1:       pick_value = 32'sh7FFF_FFFF;
                        2:       pick_value = '0;
                        3:       pick_value = -32'sd1;
                        default: pick_value = 32'sd1;
                    endcase
                default:    pick_value = word_t'($urandom);
            endcase
        end
    endfunction

    task automatic queue_word(input word_t v, input bit l, input bit hold);
        begin
            feed_q.push_back('{w: '{value: v, last: l}, hold_off: hold});
            words_queued++;
        end
    endtask

    task automatic queue_list(input int n, input val_style_e style, input bit hold);
        int i;
        begin
            for (i = 0; i < n; i++)
                queue_word(pick_value(style), (i == n - 1), hold && (i == 0));
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_CAP) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("signed_int_array_sorter_core_tb: FAIL");
        $finish;
    end

    // Sender: a new word goes out once the previous one has been taken.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            src_gap   = 0;
        end else begin
            if (in_valid && in_ready) begin
                sort_in_word(in_data);
                words_taken++;
            end
            if (!in_valid || in_ready) begin
                if (feed_q.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (src_gap > 0) begin
                    src_gap--;
                    in_valid <= 1'b0;
                end else if (feed_q.size() >= CALM_TAIL && $urandom_range(0, 4) == 0) begin
                    src_gap = $urandom_range(1, 3) - 1;
                    in_valid <= 1'b0;
                end else if (feed_q[0].hold_off && sorted_due.size() != 0) begin
                    // Hold this list back until the previous one has fully drained.
                    in_valid <= 1'b0;
                end else begin
                    next_feed = feed_q.pop_front();
                    in_valid <= 1'b1;
                    in_data  <= next_feed.w;
                end
            end
        end
    end

    // Receiver: checks each word taken and stalls in short bursts.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            snk_gap    = 0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (sorted_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result value_res %0d last_res %0b overflow %0b",
                             $time, out_data.value_res, out_data.last_res,
                             out_data.overflow);
                end else begin
                    due = sorted_due.pop_front();
                    if (out_data.value_res !== due.value_res) begin
                        errors++;
                        $display("%0t: value_res expected %0d got %0d",
                                 $time, due.value_res, out_data.value_res);
                    end
                    if (out_data.last_res !== due.last_res) begin
                        errors++;
                        $display("%0t: last_res expected %0b got %0b",
                                 $time, due.last_res, out_data.last_res);
                    end
                    if (out_data.overflow !== due.overflow) begin
                        errors++;
                        $display("%0t: overflow expected %0b got %0b",
                                 $time, due.overflow, out_data.overflow);
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                out_ready <= 1'b0;
            end else if (feed_q.size() >= CALM_TAIL && $urandom_range(0, 4) == 0) begin
                snk_gap = $urandom_range(1, 3) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        errors        = 0;
        words_taken   = 0;
        lists_sorted  = 0;
        lists_spilled = 0;
        results_seen  = 0;
        words_queued  = 0;
        spill_seen    = 1'b0;
        rst_n         = 1'b0;

        // Single-word lists at the extremes, then small lists that exercise
        // signed ordering, duplicates and already reversed or sorted input.
        queue_word(32'sh7FFF_FFFF, 1'b1, 1'b0);
        queue_word(32'sh8000_0000, 1'b1, 1'b0);
        queue_word('0, 1'b0, 1'b0);
        queue_word(-32'sd1, 1'b1, 1'b0);
        queue_word(32'sh7FFF_FFFF, 1'b0, 1'b0);
        queue_word(32'sh8000_0000, 1'b0, 1'b0);
        queue_word('0, 1'b0, 1'b0);
        queue_word(-32'sd1, 1'b0, 1'b0);
        queue_word(32'sd1, 1'b1, 1'b0);
        queue_word(32'sd5, 1'b0, 1'b0);
        queue_word(32'sd5, 1'b0, 1'b0);
        queue_word(32'sd5, 1'b1, 1'b0);
        queue_word(32'sd4, 1'b0, 1'b0);
        queue_word(32'sd3, 1'b0, 1'b0);
        queue_word(-32'sd2, 1'b0, 1'b0);
        queue_word(-32'sd9, 1'b1, 1'b0);
        queue_word(-32'sd7, 1'b0, 1'b0);
        queue_word(-32'sd1, 1'b0, 1'b0);
        queue_word(32'sd2, 1'b0, 1'b0);
        queue_word(32'sd8, 1'b1, 1'b0);

        // Random lists, mostly short, with one list that exactly fills the
        // chain and one that overruns it so that the word marked last is
        // itself dropped.
        while (words_queued < 55)
            queue_list($urandom_range(1, 8), val_style_e'($urandom_range(0, 3)),
                       ($urandom_range(0, 5) == 0));
        queue_list(CAP, VAL_MIXED, 1'b1);
        while (words_queued < 140)
            queue_list(($urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
                                                   : $urandom_range(1, 8),
                       val_style_e'($urandom_range(0, 3)), ($urandom_range(0, 5) == 0));
        queue_list(CAP + 2, VAL_MIXED, 1'b1);
        while (words_queued < 215)
            queue_list($urandom_range(1, 8), val_style_e'($urandom_range(0, 3)), 1'b0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (feed_q.size() != 0 || in_valid)
            @(posedge clk);
        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sorted %0d lists from %0d words, %0d of them overrunning the chain;",
                 lists_sorted, words_taken, lists_spilled);
        $display("%0d sorted words checked under random stalls on both sides.",
                 results_seen);
        if (errors == 0)
            $display("signed_int_array_sorter_core_tb: PASS");
        else
            $display("signed_int_array_sorter_core_tb: FAIL");
        $finish;
    end

endmodule
